// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the rotation gate update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define QRG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define QRG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/qrg_pkg.sv =====
// Types, constants and the direction lookup of the rotation gate update block.
package qrg_pkg;

	localparam int ROT_W     = 14;
	localparam int CFG_IDX_W = 1;

	localparam logic [ROT_W-1:0] ROT_LOW_RST  = 14'd328;
	localparam logic [ROT_W-1:0] ROT_HIGH_RST = 14'd1638;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_LOW  = 1'b0,
		REG_ROT_HIGH = 1'b1
	} cfg_reg_t;

	// Two's complement direction code: -1, 0, +1.
	typedef enum logic [1:0] {
		DIR_ZERO = 2'b00,
		DIR_POS  = 2'b01,
		DIR_NEG  = 2'b11
	} dir_t;

	// Rotation direction from the half-angle quadrant and the two bits.
	// On an axis one of cos/sin is zero, so only the zero test and the random
	// bit matter; off axis the sign of cos*sin is positive in even quadrants.
	function automatic dir_t pick_dir(
		input logic [1:0] quad,
		input logic       axis,
		input logic       obs,
		input logic       best,
		input logic       rnd
	);
		dir_t rdir;
		dir_t d;
		rdir = rnd ? DIR_NEG : DIR_POS;
		if (obs == best) begin
			d = DIR_ZERO;
		end else if (axis) begin
			d = (quad[0] != obs) ? DIR_ZERO : rdir;
		end else begin
			d = (quad[0] == obs) ? DIR_POS : DIR_NEG;
		end
		return d;
	endfunction

endpackage

// ===== design/qubit_rotation_gate_update.sv =====
// Qubit rotation gate update: theta +/- 2*(low + (high-low)*|fc-fb|/max), modulo 2^PHASE_BITS.
// Stages from the accepting edge to m_tvalid: input, multiply, 14 divider rows, rotation,
// output register. Throughput: one request per cycle while the output is not held, set by
// the pipelined restoring divider that retires one quotient bit per row.
// The whole pipeline holds while m_tvalid is high and m_tready is low.
// Reset clears all valid bits and loads rot_low = 328, rot_high = 1638.
`include "assert_macros.svh"

module qubit_rotation_gate_update
	import qrg_pkg::*;
#(
	parameter int PHASE_BITS   = 16,
	parameter int FITNESS_BITS = 31
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	// tdata from bit 0: theta, observed_bit, best_bit, fitness_cur, fitness_best,
	// random_bit, zero fill to whole bytes
	input  logic                                            s_tvalid,
	output logic                                            s_tready,
	input  logic [((PHASE_BITS+2*FITNESS_BITS+3+7)/8)*8-1:0] s_tdata,
	// tdata from bit 0: new_theta, direction (2 bits signed), zero fill to whole bytes
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	output logic [((PHASE_BITS+2+7)/8)*8-1:0]               m_tdata,
	// configuration writes
	input  logic                                            cfg_valid,
	output logic                                            cfg_ready,
	input  logic [CFG_IDX_W-1:0]                            cfg_index,
	input  logic [ROT_W-1:0]                                cfg_data
);

	localparam int OUT_W = ((PHASE_BITS + 2 + 7) / 8) * 8;
	localparam int OB_POS = PHASE_BITS;
	localparam int BB_POS = PHASE_BITS + 1;
	localparam int FC_POS = PHASE_BITS + 2;
	localparam int FB_POS = PHASE_BITS + 2 + FITNESS_BITS;
	localparam int RB_POS = PHASE_BITS + 2 + 2 * FITNESS_BITS;
	localparam int NUM_W  = ROT_W + FITNESS_BITS;
	// adder width for theta +/- 2*rot; the amount can be wider than a narrow phase
	localparam int ADD_W  = (PHASE_BITS > ROT_W + 1) ? PHASE_BITS : ROT_W + 1;

	// Side data that rides alongside the arithmetic.
	typedef struct packed {
		logic [PHASE_BITS-1:0] theta;
		dir_t                  dir;
		logic [ROT_W-1:0]      lo;
		logic [ROT_W-1:0]      hi;
		logic                  up;   // high >= low
		logic                  mxz;  // both fitnesses zero
	} side_t;

	// ---------------------------------------------------------------- config
	logic [ROT_W-1:0] rot_low_q;
	logic [ROT_W-1:0] rot_high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_low_q  <= ROT_LOW_RST;
			rot_high_q <= ROT_HIGH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROT_LOW:  rot_low_q  <= cfg_data;
				REG_ROT_HIGH: rot_high_q <= cfg_data;
			endcase
		end
	end

	// ---------------------------------------------------------------- flow
	// Advance every stage together whenever the output slot is free or taken.
	logic adv;
	logic res_vld_s4;

	assign adv      = !res_vld_s4 || m_tready;
	assign s_tready = adv;

	// ---------------------------------------------------------------- stage 1
	// Unpack the request, pick the direction, form max, |diff| and the span.
	logic [PHASE_BITS-1:0]   in_theta;
	logic [FITNESS_BITS-1:0] in_fc;
	logic [FITNESS_BITS-1:0] in_fb;
	logic                    fc_gt;
	side_t                   in_side;
	logic [FITNESS_BITS-1:0] in_mx;
	logic [FITNESS_BITS-1:0] in_diff;
	logic [ROT_W-1:0]        in_span;

	always_comb begin
		in_theta = s_tdata[PHASE_BITS-1:0];
		in_fc    = s_tdata[FC_POS +: FITNESS_BITS];
		in_fb    = s_tdata[FB_POS +: FITNESS_BITS];
		fc_gt    = in_fc > in_fb;
		in_mx    = fc_gt ? in_fc : in_fb;
		in_diff  = fc_gt ? (in_fc - in_fb) : (in_fb - in_fc);

		in_side.theta = in_theta;
		in_side.dir   = pick_dir(in_theta[PHASE_BITS-1 -: 2],
			in_theta[PHASE_BITS-3:0] == '0,
			s_tdata[OB_POS], s_tdata[BB_POS], s_tdata[RB_POS]);
		in_side.lo    = rot_low_q;
		in_side.hi    = rot_high_q;
		in_side.up    = rot_high_q >= rot_low_q;
		in_side.mxz   = (in_fc == '0) && (in_fb == '0);
		in_span       = in_side.up ? (rot_high_q - rot_low_q) : (rot_low_q - rot_high_q);
	end

	logic                    vld_s1;
	side_t                   side_s1;
	logic [FITNESS_BITS-1:0] mx_s1;
	logic [FITNESS_BITS-1:0] diff_s1;
	logic [ROT_W-1:0]        span_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= in_side;
			mx_s1   <= in_mx;
			diff_s1 <= in_diff;
			span_s1 <= in_span;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Numerator span * |diff| for the divider; max becomes the divisor.
	logic                    vld_s2;
	side_t                   side_s2;
	logic [FITNESS_BITS-1:0] den_s2;
	logic [NUM_W-1:0]        num_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			den_s2  <= mx_s1;
			num_s2  <= NUM_W'(span_s1) * NUM_W'(diff_s1);
		end
	end

	// ---------------------------------------------------------------- divider rows
	// The quotient never exceeds the span (|diff| <= max), so it fits ROT_W bits and
	// the top of the numerator already sits below the divisor. Each row shifts in one
	// numerator bit, then compares and subtracts once.
	logic                    dv_vld_sd  [ROT_W];
	side_t                   dv_side_sd [ROT_W];
	logic [FITNESS_BITS-1:0] dv_rem_sd  [ROT_W];
	logic [FITNESS_BITS-1:0] dv_den_sd  [ROT_W];
	logic [ROT_W-1:0]        dv_quo_sd  [ROT_W];
	logic [ROT_W-1:0]        dv_low_sd  [ROT_W];

	for (genvar k = 0; k < ROT_W; k++) begin : g_div
		logic                    vld_in;
		side_t                   side_in;
		logic [FITNESS_BITS-1:0] rem_in;
		logic [FITNESS_BITS-1:0] den_in;
		logic [ROT_W-1:0]        quo_in;
		logic [ROT_W-1:0]        low_in;
		logic [FITNESS_BITS:0]   trial;
		logic [FITNESS_BITS:0]   trial_sub;
		logic                    take;

		if (k == 0) begin : g_first
			assign vld_in  = vld_s2;
			assign side_in = side_s2;
			assign rem_in  = num_s2[NUM_W-1:ROT_W];
			assign den_in  = den_s2;
			assign quo_in  = '0;
			assign low_in  = num_s2[ROT_W-1:0];
		end else begin : g_next
			assign vld_in  = dv_vld_sd[k-1];
			assign side_in = dv_side_sd[k-1];
			assign rem_in  = dv_rem_sd[k-1];
			assign den_in  = dv_den_sd[k-1];
			assign quo_in  = dv_quo_sd[k-1];
			assign low_in  = dv_low_sd[k-1];
		end

		always_comb begin
			trial     = {rem_in, low_in[ROT_W-1-k]};
			trial_sub = trial - {1'b0, den_in};
			take      = trial >= {1'b0, den_in};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_sd[k] <= 1'b0;
			end else if (adv) begin
				dv_vld_sd[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_side_sd[k] <= side_in;
				dv_den_sd[k]  <= den_in;
				dv_low_sd[k]  <= low_in;
				dv_rem_sd[k]  <= take ? trial_sub[FITNESS_BITS-1:0] : trial[FITNESS_BITS-1:0];
				dv_quo_sd[k]  <= {quo_in[ROT_W-2:0], take};
			end
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Rotation amount: high when both fitnesses are zero, else low +/- quotient.
	logic             vld_s3;
	side_t            side_s3;
	logic [ROT_W-1:0] rot_s3;
	side_t            dv_last_side;
	logic [ROT_W-1:0] dv_last_quo;

	assign dv_last_side = dv_side_sd[ROT_W-1];
	assign dv_last_quo  = dv_quo_sd[ROT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= dv_vld_sd[ROT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= dv_last_side;
			if (dv_last_side.mxz) begin
				rot_s3 <= dv_last_side.hi;
			end else if (dv_last_side.up) begin
				rot_s3 <= dv_last_side.lo + dv_last_quo;
			end else begin
				rot_s3 <= dv_last_side.lo - dv_last_quo;
			end
		end
	end

	// ---------------------------------------------------------------- stage 4
	// Apply twice the rotation in the chosen direction; wrap to the phase width.
	logic [ADD_W-1:0]      th_w;
	logic [ADD_W-1:0]      amt_w;
	logic [ADD_W-1:0]      sum_w;
	logic [PHASE_BITS-1:0] res_theta_s4;
	dir_t                  res_dir_s4;

	always_comb begin
		th_w  = ADD_W'(side_s3.theta);
		amt_w = ADD_W'({rot_s3, 1'b0});
		unique case (side_s3.dir)
			DIR_POS:  sum_w = th_w + amt_w;
			DIR_NEG:  sum_w = th_w - amt_w;
			default:  sum_w = th_w;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s4 <= 1'b0;
		end else if (adv) begin
			res_vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_theta_s4 <= sum_w[PHASE_BITS-1:0];
			res_dir_s4   <= side_s3.dir;
		end
	end

	assign m_tvalid = res_vld_s4;
	assign m_tdata  = OUT_W'({res_dir_s4, res_theta_s4});

	// ---------------------------------------------------------------- checks
	`QRG_ASSERT_IMP(a_div_rem_below_den, dv_vld_sd[ROT_W-1] && !dv_last_side.mxz, dv_rem_sd[ROT_W-1] < dv_den_sd[ROT_W-1], "divider remainder not below divisor")
	`QRG_ASSERT_IMP(a_div_quo_in_span, dv_vld_sd[ROT_W-1] && !dv_last_side.mxz, (dv_last_side.up && dv_last_quo <= dv_last_side.hi - dv_last_side.lo) || (!dv_last_side.up && dv_last_quo <= dv_last_side.lo - dv_last_side.hi), "quotient exceeds rotation span")
	`QRG_ASSERT_IMP(a_rot_within_bounds, vld_s3, (rot_s3 >= side_s3.lo && rot_s3 <= side_s3.hi) || (rot_s3 <= side_s3.lo && rot_s3 >= side_s3.hi), "rotation outside low/high bounds")
	`QRG_ASSERT_NXT(a_zero_dir_keeps_theta, adv && vld_s3 && side_s3.dir == DIR_ZERO, res_theta_s4 == $past(side_s3.theta), "angle changed with zero direction")

endmodule
